@@ rtl/cct_pkg.sv @@
// Shared types, constants and calendar helper functions for the calendar clock.
package cct_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int H12_W   = 4;

    localparam logic [YEAR_W-1:0]  YEAR_MIN     = 14'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_DEFAULT = 14'd2000;
    localparam logic [MONTH_W-1:0] MONTH_FIRST  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST   = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR    = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN    = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP    = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV    = 4'd11;
    localparam logic [DAY_W-1:0]   DAY_FIRST    = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;
    localparam logic [DAY_W-1:0]   DAYS_31      = 5'd31;
    localparam logic [DAY_W-1:0]   DAYS_30      = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_29      = 5'd29;
    localparam logic [DAY_W-1:0]   DAYS_28      = 5'd28;
    localparam logic [HOUR_W-1:0]  HOUR_LAST    = 5'd23;
    localparam logic [HOUR_W-1:0]  HOUR_NOON    = 5'd12;
    localparam logic [MIN_W-1:0]   MIN_LAST     = 6'd59;
    localparam logic [SEC_W-1:0]   SEC_LAST     = 6'd59;
    localparam logic [H12_W-1:0]   H12_TOP      = 4'd12;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // floor(y / 25) = (y * DIV25_MUL) >> DIV25_SHIFT for every 14-bit y
    localparam int               DIV25_SHIFT = 21;
    localparam logic [16:0]      DIV25_MUL   = 17'd83887;

    typedef struct packed {
        logic               kind;
        logic [MONTH_W-1:0] load_month;
        logic [DAY_W-1:0]   load_day;
        logic [YEAR_W-1:0]  load_year;
        logic [HOUR_W-1:0]  load_hour;
        logic [MIN_W-1:0]   load_minute;
        logic [SEC_W-1:0]   load_second;
    } cct_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  cur_year;
        logic [MONTH_W-1:0] cur_month;
        logic [DAY_W-1:0]   cur_day;
        logic [HOUR_W-1:0]  cur_hour;
        logic [MIN_W-1:0]   cur_minute;
        logic [SEC_W-1:0]   cur_second;
        logic [H12_W-1:0]   hour_twelve;
        logic               is_pm;
    } cct_result_t;

    // Item after range checks but for the day, handed from the input stage to the clock core
    typedef struct packed {
        logic               kind;
        logic [YEAR_W-1:0]  year;
        logic               leap;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } cct_stage_t;

    // Gregorian rule: leap = div4 && (!div25 || div16)
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [YEAR_W+16:0] prod;
        logic [9:0]         q;
        logic [YEAR_W-1:0]  q25;
        logic               div25;
        prod  = (YEAR_W+17)'(y) * (YEAR_W+17)'(DIV25_MUL);
        q     = prod[DIV25_SHIFT+9:DIV25_SHIFT];
        q25   = {q, 4'b0} + {1'b0, q, 3'b0} + {4'b0, q};
        div25 = (q25 == y);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_30;
            MONTH_FEB: len = leap ? DAYS_29 : DAYS_28;
            default:   len = DAYS_31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/cct_stream_if.sv @@
// Valid/ready stream interface used by the calendar clock channels.
interface cct_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/calendar_clock_tick.sv @@
// Calendar clock top level: input register stage feeding the clock core.
//
// Gregorian real-time clock calendar with year, month, day, hour, minute, second.
// Channel item (cct_item_t): kind 0 advances the clock by one second with full
// carry and leap-year handling; kind 1 loads all six fields, each range-checked
// and replaced by its default when out of range. The year holds at 9999-12-31
// 23:59:59 and never rolls over.
// Channel result (cct_result_t): exactly one transaction per item, carrying the
// time after that item plus the 12-hour hour and a PM flag.
// Two register stages (input register, then state update and result register):
// an accepted item is held in the input register, then the core takes it into
// the result register and raises result.valid. Throughput: one item per cycle
// with result.ready high; state update and next-year leap check are combinational.
// Reset (rst_n low, asynchronous) sets 2000-01-01 00:00:00 and empties both
// register stages. When the receiver holds result.ready low the result stays
// registered; one more item can still enter the input stage, after which
// item.ready drops until the result is taken.
module calendar_clock_tick (
    input  logic       clk,
    input  logic       rst_n,
    cct_stream_if.sink   item,
    cct_stream_if.source result
);
    import cct_pkg::*;

    logic       stage_valid;
    logic       stage_ready;
    cct_stage_t stage;

    cct_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .stage_valid (stage_valid),
        .stage       (stage),
        .stage_ready (stage_ready)
    );

    cct_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .stage_ready (stage_ready),
        .result      (result)
    );

endmodule

@@ rtl/cct_in_stage.sv @@
// Input register: captures a transaction and range-checks the load fields but the day.
module cct_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    cct_stream_if.sink         item,
    output logic               stage_valid,
    output cct_pkg::cct_stage_t stage,
    input  logic               stage_ready
);
    import cct_pkg::*;

    cct_item_t  in_data;
    cct_stage_t stage_next;
    cct_stage_t stage_reg;
    logic       valid_reg;
    logic       month_ok;

    assign in_data = item.payload;
    assign month_ok = (in_data.load_month >= MONTH_FIRST) && (in_data.load_month <= MONTH_LAST);

    always_comb
    begin
        stage_next.kind   = in_data.kind;
        stage_next.year   = ((in_data.load_year >= YEAR_MIN) && (in_data.load_year <= YEAR_MAX))
                            ? in_data.load_year : YEAR_DEFAULT;
        stage_next.leap   = leap_year(stage_next.year);
        stage_next.month  = month_ok ? in_data.load_month : MONTH_FIRST;
        // day is checked against the month length in the core
        stage_next.day    = in_data.load_day;
        stage_next.hour   = (in_data.load_hour <= HOUR_LAST) ? in_data.load_hour : '0;
        stage_next.minute = (in_data.load_minute <= MIN_LAST) ? in_data.load_minute : '0;
        stage_next.second = (in_data.load_second <= SEC_LAST) ? in_data.load_second : '0;
    end

    assign item.ready  = !valid_reg || stage_ready;
    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (stage_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

@@ rtl/cct_core.sv @@
// Clock/calendar state, next-state logic for tick and load, and result register.
module cct_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               stage_valid,
    input  cct_pkg::cct_stage_t stage,
    output logic               stage_ready,
    cct_stream_if.source       result
);
    import cct_pkg::*;

    logic [YEAR_W-1:0]  year_reg,   year_next;
    logic [MONTH_W-1:0] month_reg,  month_next;
    logic [DAY_W-1:0]   day_reg,    day_next;
    logic [HOUR_W-1:0]  hour_reg,   hour_next;
    logic [MIN_W-1:0]   minute_reg, minute_next;
    logic [SEC_W-1:0]   second_reg, second_next;
    logic               leap_reg,   leap_next;
    logic               res_valid_reg;
    cct_result_t        res_reg,    res_next;
    logic               take;
    logic               at_end;
    logic               load_day_ok;
    logic [DAY_W-1:0]   cur_len;
    logic               leap_following;
    logic [YEAR_W-1:0]  year_inc;

    assign stage_ready = !res_valid_reg || result.ready;
    assign take        = stage_valid && stage_ready;

    assign cur_len  = month_days(month_reg, leap_reg);
    assign year_inc = year_reg + 14'd1;
    assign leap_following = leap_year(year_inc);

    assign at_end = (year_reg >= YEAR_MAX) && (month_reg == MONTH_LAST) &&
                    (day_reg == DAY_LAST_DEC) && (hour_reg == HOUR_LAST) &&
                    (minute_reg == MIN_LAST) && (second_reg == SEC_LAST);

    assign load_day_ok = (stage.day >= DAY_FIRST) &&
                         (stage.day <= month_days(stage.month, stage.leap));

    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        leap_next   = leap_reg;
        if (stage.kind == KIND_LOAD)
        begin
            year_next   = stage.year;
            leap_next   = stage.leap;
            month_next  = stage.month;
            day_next    = load_day_ok ? stage.day : DAY_FIRST;
            hour_next   = stage.hour;
            minute_next = stage.minute;
            second_next = stage.second;
        end
        else if (!at_end)
        begin
            // carry chain: second -> minute -> hour -> day -> month -> year
            if (second_reg != SEC_LAST)
            begin
                second_next = second_reg + 6'd1;
            end
            else
            begin
                second_next = '0;
                if (minute_reg != MIN_LAST)
                begin
                    minute_next = minute_reg + 6'd1;
                end
                else
                begin
                    minute_next = '0;
                    if (hour_reg != HOUR_LAST)
                    begin
                        hour_next = hour_reg + 5'd1;
                    end
                    else
                    begin
                        hour_next = '0;
                        if (day_reg < cur_len)
                        begin
                            day_next = day_reg + 5'd1;
                        end
                        else
                        begin
                            day_next = DAY_FIRST;
                            if (month_reg != MONTH_LAST)
                            begin
                                month_next = month_reg + 4'd1;
                            end
                            else
                            begin
                                month_next = MONTH_FIRST;
                                year_next  = year_inc;
                                leap_next  = leap_following;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        res_next.cur_year    = year_next;
        res_next.cur_month   = month_next;
        res_next.cur_day     = day_next;
        res_next.cur_hour    = hour_next;
        res_next.cur_minute  = minute_next;
        res_next.cur_second  = second_next;
        res_next.is_pm       = (hour_next >= HOUR_NOON);
        if (hour_next == '0)
        begin
            res_next.hour_twelve = H12_TOP;
        end
        else if (hour_next > HOUR_NOON)
        begin
            res_next.hour_twelve = H12_W'(hour_next - HOUR_NOON);
        end
        else
        begin
            res_next.hour_twelve = hour_next[H12_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg      <= YEAR_DEFAULT;
            month_reg     <= MONTH_FIRST;
            day_reg       <= DAY_FIRST;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            leap_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
                leap_reg   <= leap_next;
            end
            if (take)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

endmodule

@@ rtl/cct_checker.sv @@
// Port-level assertions for the calendar clock, bound to the top level.
module cct_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input cct_pkg::cct_result_t result_payload
);
    import cct_pkg::*;

    // stalled result transaction keeps its payload
    property p_hold_stalled;
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> $stable(result_payload);
    endproperty
    a_hold_stalled: assert property (p_hold_stalled)
        else $error("result payload changed while stalled");

    property p_time_range;
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_payload.cur_second <= SEC_LAST) &&
                         (result_payload.cur_minute <= MIN_LAST) &&
                         (result_payload.cur_hour <= HOUR_LAST);
    endproperty
    a_time_range: assert property (p_time_range)
        else $error("time of day out of range");

    property p_date_range;
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_payload.cur_year >= YEAR_MIN) &&
                         (result_payload.cur_year <= YEAR_MAX) &&
                         (result_payload.cur_month >= MONTH_FIRST) &&
                         (result_payload.cur_month <= MONTH_LAST) &&
                         (result_payload.cur_day >= DAY_FIRST) &&
                         (result_payload.cur_day <=
                          month_days(result_payload.cur_month,
                                     leap_year(result_payload.cur_year)));
    endproperty
    a_date_range: assert property (p_date_range)
        else $error("date out of range");

    property p_twelve_hour;
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_payload.is_pm == (result_payload.cur_hour >= HOUR_NOON)) &&
                         (result_payload.hour_twelve >= 4'd1) &&
                         (result_payload.hour_twelve <= H12_TOP) &&
                         ((result_payload.hour_twelve == H12_TOP) ==
                          ((result_payload.cur_hour == '0) ||
                           (result_payload.cur_hour == HOUR_NOON)));
    endproperty
    a_twelve_hour: assert property (p_twelve_hour)
        else $error("12-hour form disagrees with 24-hour hour");

endmodule

bind calendar_clock_tick cct_checker u_cct_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);

@@ test/tb_calendar_clock_tick.sv @@
// Testbench for calendar_clock_tick: directed and random ticks and loads checked against a calendar model.
`timescale 1ns / 1ps

module tb_calendar_clock_tick;

    import cct_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 220;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cct_stream_if #(.payload_t(cct_item_t))   item_ch ();
    cct_stream_if #(.payload_t(cct_result_t)) result_ch ();

    calendar_clock_tick dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    cct_item_t   items_to_send[$];
    cct_result_t expected_times[$];

    int unsigned items_queued   = 0;
    int unsigned items_accepted = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        item_taken     = 1'b0;
    logic        hold_off       = 1'b0;
    logic        hold_go        = 1'b0;

    // calendar model state
    logic [YEAR_W-1:0]  cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [DAY_W-1:0]   cal_day;
    logic [HOUR_W-1:0]  cal_hour;
    logic [MIN_W-1:0]   cal_min;
    logic [SEC_W-1:0]   cal_sec;

    function automatic bit gregorian_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        int unsigned n;
        case (m)
            4, 6, 9, 11: n = 30;
            2:           n = gregorian_leap(y) ? 29 : 28;
            default:     n = 31;
        endcase
        return n;
    endfunction

    task automatic reset_calendar();
        cal_year  = 14'd2000;
        cal_month = 4'd1;
        cal_day   = 5'd1;
        cal_hour  = '0;
        cal_min   = '0;
        cal_sec   = '0;
    endtask

    task automatic advance_calendar(input cct_item_t it, output cct_result_t res);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        if (it.kind == KIND_LOAD)
        begin
            y = 32'(it.load_year);
            m = 32'(it.load_month);
            d = 32'(it.load_day);
            cal_year  = YEAR_W'((y >= 1900 && y <= 9999) ? y : 2000);
            cal_month = MONTH_W'((m >= 1 && m <= 12) ? m : 1);
            cal_day   = DAY_W'((d >= 1 && d <= days_in(32'(cal_month), 32'(cal_year))) ? d : 1);
            cal_hour  = HOUR_W'((it.load_hour < 24) ? 32'(it.load_hour) : 0);
            cal_min   = MIN_W'((it.load_minute < 60) ? 32'(it.load_minute) : 0);
            cal_sec   = SEC_W'((it.load_second < 60) ? 32'(it.load_second) : 0);
        end
        else if (!(cal_year >= 9999 && cal_month == 12 && cal_day == 31 &&
                   cal_hour == 23 && cal_min == 59 && cal_sec == 59))
        begin
            // carry chain, each level only when the one below wraps
            if (cal_sec == 59)
            begin
                cal_sec = '0;
                if (cal_min == 59)
                begin
                    cal_min = '0;
                    if (cal_hour == 23)
                    begin
                        cal_hour = '0;
                        if (32'(cal_day) >= days_in(32'(cal_month), 32'(cal_year)))
                        begin
                            cal_day = 5'd1;
                            if (cal_month == 12)
                            begin
                                cal_month = 4'd1;
                                cal_year  = cal_year + 14'd1;
                            end
                            else
                                cal_month = cal_month + 4'd1;
                        end
                        else
                            cal_day = cal_day + 5'd1;
                    end
                    else
                        cal_hour = cal_hour + 5'd1;
                end
                else
                    cal_min = cal_min + 6'd1;
            end
            else
                cal_sec = cal_sec + 6'd1;
        end
        res.cur_year    = cal_year;
        res.cur_month   = cal_month;
        res.cur_day     = cal_day;
        res.cur_hour    = cal_hour;
        res.cur_minute  = cal_min;
        res.cur_second  = cal_sec;
        res.hour_twelve = H12_W'((cal_hour == 0 || cal_hour == 12) ? 12 : 32'(cal_hour) % 12);
        res.is_pm       = (cal_hour >= 12);
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic cct_item_t random_item(input logic kind);
        cct_item_t it;
        it.kind        = kind;
        it.load_month  = MONTH_W'($urandom);
        it.load_day    = DAY_W'($urandom);
        it.load_year   = YEAR_W'($urandom);
        it.load_hour   = HOUR_W'($urandom);
        it.load_minute = MIN_W'($urandom);
        it.load_second = SEC_W'($urandom);
        return it;
    endfunction

    task automatic queue_item(input cct_item_t it);
        items_to_send.push_back(it);
        items_queued++;
    endtask

    task automatic queue_load(input int unsigned y, input int unsigned m, input int unsigned d,
                              input int unsigned h, input int unsigned mi,
                              input int unsigned s);
        cct_item_t it;
        it.kind        = KIND_LOAD;
        it.load_year   = YEAR_W'(y);
        it.load_month  = MONTH_W'(m);
        it.load_day    = DAY_W'(d);
        it.load_hour   = HOUR_W'(h);
        it.load_minute = MIN_W'(mi);
        it.load_second = SEC_W'(s);
        queue_item(it);
    endtask

    task automatic queue_ticks(input int unsigned n);
        repeat (n)
        begin
            queue_item(random_item(KIND_TICK));
        end
    endtask

    task automatic queue_directed();
        queue_ticks(1);                                 // first tick after reset
        queue_load(0, 0, 0, 0, 0, 0);                   // year, month and day below range
        queue_load(16383, 15, 31, 31, 63, 63);          // every field at all ones
        queue_load(1899, 6, 15, 24, 60, 60);            // year, hour, minute, second out
        queue_load(10000, 13, 10, 12, 30, 30);          // year and month above range
        queue_load(1900, 1, 1, 0, 0, 0);                // lowest valid values
        queue_load(9999, 12, 31, 23, 59, 58);           // one second before the end
        queue_ticks(3);                                 // reaches the end, then holds
        queue_load(1999, 12, 31, 23, 59, 59);
        queue_ticks(1);                                 // year carry
        queue_load(2000, 2, 29, 11, 59, 59);            // leap by 400
        queue_ticks(1);                                 // noon
        queue_load(1900, 2, 29, 13, 0, 0);              // century, not leap: day to 1
        queue_load(2100, 2, 29, 23, 0, 0);
        queue_load(2024, 2, 28, 23, 59, 59);
        queue_ticks(2);                                 // Feb 29 then on
        queue_load(2023, 2, 28, 23, 59, 59);
        queue_ticks(1);                                 // straight to March
        queue_load(2023, 4, 31, 5, 5, 5);               // day past a 30-day month
        queue_load(2023, 4, 30, 23, 59, 59);
        queue_ticks(1);
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned made;
        int unsigned y;
        int unsigned m;
        int unsigned len;
        int unsigned d;
        int unsigned n;
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                begin
                    // load near a rollover, then tick towards or across it
                    case ($urandom_range(7))
                        0:       y = 1900;
                        1:       y = 2000;
                        2:       y = 2100;
                        3:       y = 2400;
                        4:       y = 9999;
                        5:       y = 4 * $urandom_range(475, 2499);
                        default: y = $urandom_range(1900, 9999);
                    endcase
                    case ($urandom_range(3))
                        0:       m = 12;
                        1:       m = 2;
                        default: m = $urandom_range(1, 12);
                    endcase
                    len = days_in(m, y);
                    case ($urandom_range(3))
                        0, 1:    d = len;
                        2:       d = len - 1;
                        default: d = $urandom_range(0, 31);
                    endcase
                    queue_load(y, m, d,
                               ($urandom_range(3) != 0) ? 23 : $urandom_range(0, 23),
                               ($urandom_range(3) != 0) ? 59 : $urandom_range(0, 59),
                               $urandom_range(55, 59));
                    n = $urandom_range(1, 8);
                    queue_ticks(n);
                    made += n + 1;
                end
                6, 7:
                begin
                    // load with arbitrary bits in every field
                    queue_item(random_item(KIND_LOAD));
                    n = $urandom_range(0, 3);
                    queue_ticks(n);
                    made += n + 1;
                end
                default:
                begin
                    n = $urandom_range(1, 12);
                    queue_ticks(n);
                    made += n;
                end
            endcase
        end
    endtask

    // ---------------- item driver ----------------
    always @(negedge clk)
    begin
        if (rst_n && (!item_ch.valid || item_taken))
        begin
            if (items_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_ch.payload <= items_to_send.pop_front();
                item_ch.valid   <= 1'b1;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // ---------------- result ready ----------------
    always @(negedge clk)
    begin
        if (rst_n)
            result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off, counted here
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ---------------- monitor and checker ----------------
    always @(posedge clk)
    begin : monitor
        cct_result_t want;
        cct_result_t got;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.payload;
                if (expected_times.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                begin
                    want = expected_times.pop_front();
                    check_field("cur_year", 32'(got.cur_year), 32'(want.cur_year));
                    check_field("cur_month", 32'(got.cur_month), 32'(want.cur_month));
                    check_field("cur_day", 32'(got.cur_day), 32'(want.cur_day));
                    check_field("cur_hour", 32'(got.cur_hour), 32'(want.cur_hour));
                    check_field("cur_minute", 32'(got.cur_minute), 32'(want.cur_minute));
                    check_field("cur_second", 32'(got.cur_second), 32'(want.cur_second));
                    check_field("hour_twelve", 32'(got.hour_twelve), 32'(want.hour_twelve));
                    check_field("is_pm", 32'(got.is_pm), 32'(want.is_pm));
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                advance_calendar(item_ch.payload, want);
                expected_times.push_back(want);
                items_accepted++;
            end
            item_taken <= item_ch.valid && item_ch.ready;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("calendar_clock_tick verification failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input bit long_hold);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (long_hold)
            hold_go = 1'b1;
        queue_random(PHASE_ITEMS);
        wait (items_to_send.size() == 0);
    endtask

    initial
    begin
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        result_ch.ready = 1'b0;
        reset_calendar();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        run_phase(0, 0, 1'b0);
        run_phase(86, 0, 1'b0);
        run_phase(0, 86, 1'b0);
        run_phase(32, 32, 1'b0);
        run_phase(0, 0, 1'b1);

        wait (items_accepted == items_queued && expected_times.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_times.size() == 0)
            $display("calendar_clock_tick verification clean");
        else
            $display("calendar_clock_tick verification failed");
        $finish;
    end

endmodule

@@ calendar_clock_tick.f @@
rtl/cct_pkg.sv
rtl/cct_stream_if.sv
rtl/cct_in_stage.sv
rtl/cct_core.sv
rtl/calendar_clock_tick.sv
rtl/cct_checker.sv
test/tb_calendar_clock_tick.sv
